@@ sv/strm_pkg.sv @@
// Shared types and codes of the sparse table range minimum unit.
package strm_pkg;

  // Fixed field widths
  localparam int VALUE_W = 64;
  localparam int IDX_W   = 10;
  localparam int LEN_W   = IDX_W + 1;
  localparam int POT_W   = 4;

  // Default sizing
  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;

  // Request types
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] element_value;
    logic [IDX_W-1:0]          range_first;
    logic [IDX_W-1:0]          range_last;
  } strm_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic [1:0]                status;
  } strm_rsp_t;

endpackage

@@ sv/strm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module strm_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sparse_table_range_min_unit.sv @@
// Range-minimum engine over signed 64-bit values kept as an incrementally built sparse table.
//
// Usage: one input channel (in_valid_i/in_ready_o/in_data_i) takes clear, append and
// query items; one output channel (out_valid_o/out_ready_i/out_data_o) gives exactly
// one result per item, in order. The unit works on one item at a time and holds
// in_ready_o low until that item's result has moved into the output register.
// Clear, rejected and unknown items need no table access; a query makes two reads
// of the table RAM and one compare; an append writes level 0 and then each of the
// levels above level 0 whose window ends at the new element (at most Levels-1). The
// append loop is set by the single table RAM: one read and one write per level,
// overlapped. A new item is taken the cycle after the previous result enters the
// output register, even while that result still waits.
// When the receiver stalls, the result holds in the output register and the next
// finished result waits inside the unit. Reset empties the table (count zero);
// the table RAM itself is not cleared, since only words written since the last
// clear are ever read.
module sparse_table_range_min_unit
  import strm_pkg::*;
#(
  parameter int MaxElements = strm_pkg::MAX_ELEMENTS,
  parameter int Levels      = strm_pkg::LEVELS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  strm_pkg::strm_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output strm_pkg::strm_rsp_t out_data_o
);

  localparam int CntW  = $clog2(MaxElements + 1);
  localparam int PosW  = $clog2(MaxElements);
  localparam int LvlW  = $clog2(Levels + 1);
  localparam int SumW  = ((CntW > Levels) ? CntW : Levels) + 1;
  localparam int CmpW  = (CntW > IDX_W) ? CntW : IDX_W;
  localparam int Depth = MaxElements * Levels;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_APP0 = 7'b0000010,
    ST_APPL = 7'b0000100,
    ST_QRY0 = 7'b0001000,
    ST_QRY1 = 7'b0010000,
    ST_QRY2 = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e                    state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [LvlW-1:0]           lvl_q, lvl_d;
  logic                      out_valid_q;
  strm_rsp_t                 out_q;
  strm_rsp_t                 res_q, res_d;
  logic [PosW-1:0]           n_q;
  logic [PosW-1:0]           first_q;
  logic [PosW-1:0]           last_q;
  logic [LvlW-1:0]           pot_q;
  logic signed [VALUE_W-1:0] value_q;
  logic signed [VALUE_W-1:0] carry_q, carry_d;

  logic                      accept;
  logic                      load_out;
  logic [LEN_W-1:0]          q_len;
  logic [POT_W-1:0]          q_pot;
  logic [LvlW-1:0]           q_pot_cl;
  logic                      q_err;
  logic                      full;

  logic [SumW-1:0]           np1;
  logic [SumW-1:0]           wr_start;
  logic [LvlW-1:0]           tgt;
  logic [SumW-1:0]           rd_pow;
  logic [SumW-1:0]           rd_start;
  logic                      has_next;
  logic [LvlW-1:0]           rd_lvl;
  logic [SumW-1:0]           q_start;
  logic signed [VALUE_W-1:0] rd_word;
  logic signed [VALUE_W-1:0] new_min;

  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [AddrW-1:0]          ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;

  // Level-major layout: word (pos, lvl) sits at lvl * MaxElements + pos
  function automatic logic [AddrW-1:0] addr_of(input logic [LvlW-1:0] lv,
                                               input logic [PosW-1:0] pos);
    return AddrW'(lv) * AddrW'(MaxElements) + AddrW'(pos);
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Query decode at acceptance
  assign q_len = LEN_W'(in_data_i.range_last) - LEN_W'(in_data_i.range_first) + LEN_W'(1);
  assign q_err = (in_data_i.range_first > in_data_i.range_last) ||
                 (CmpW'(in_data_i.range_last) >= CmpW'(cnt_q));
  assign full  = (cnt_q >= CntW'(MaxElements));

  always_comb begin
    q_pot = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (q_len[i]) begin
        q_pot = POT_W'(i);
      end
    end
    if (32'(q_pot) > Levels - 1) begin
      q_pot_cl = LvlW'(Levels - 1);
    end else begin
      q_pot_cl = LvlW'(q_pot);
    end
  end

  // Window starts for the level being written and the level being read ahead
  assign np1      = SumW'(n_q) + SumW'(1);
  assign wr_start = np1 - (SumW'(1) << lvl_q);
  assign tgt      = (state_q == ST_APP0) ? lvl_q : lvl_q + LvlW'(1);
  assign rd_pow   = SumW'(1) << tgt;
  assign rd_start = np1 - rd_pow;
  assign has_next = (32'(tgt) < Levels) && (rd_pow <= np1);
  assign rd_lvl   = (state_q == ST_APP0) ? lvl_q - LvlW'(1) : lvl_q;
  assign q_start  = SumW'(last_q) + SumW'(1) - (SumW'(1) << pot_q);

  assign rd_word = $signed(ram_rdata);
  assign new_min = (rd_word <= carry_q) ? rd_word : carry_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lvl_d     = lvl_q;
    res_d     = res_q;
    carry_d   = carry_q;
    ram_we    = 1'b0;
    ram_waddr = addr_of(lvl_q, PosW'(wr_start));
    ram_wdata = new_min;
    ram_raddr = addr_of(rd_lvl, PosW'(rd_start));

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          lvl_d   = LvlW'(1);
          state_d = ST_DONE;
          case (in_data_i.req_type)
            REQ_CLEAR: begin
              cnt_d = '0;
            end
            REQ_APPEND: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                cnt_d   = cnt_q + CntW'(1);
                state_d = ST_APP0;
              end
            end
            REQ_QUERY: begin
              if (q_err) begin
                res_d.status = STAT_BAD_RANGE;
              end else begin
                state_d = ST_QRY0;
              end
            end
            default: begin
              // unknown request: answer zero with status ok
            end
          endcase
        end
      end
      ST_APP0: begin
        // store the element at level 0 and read ahead for level 1
        ram_we    = 1'b1;
        ram_waddr = addr_of('0, n_q);
        ram_wdata = value_q;
        carry_d   = value_q;
        state_d   = has_next ? ST_APPL : ST_DONE;
      end
      ST_APPL: begin
        // combine the word read with the window just built one level down
        ram_we  = 1'b1;
        carry_d = new_min;
        lvl_d   = lvl_q + LvlW'(1);
        state_d = has_next ? ST_APPL : ST_DONE;
      end
      ST_QRY0: begin
        ram_raddr = addr_of(pot_q, first_q);
        state_d   = ST_QRY1;
      end
      ST_QRY1: begin
        ram_raddr = addr_of(pot_q, PosW'(q_start));
        carry_d   = rd_word;
        state_d   = ST_QRY2;
      end
      ST_QRY2: begin
        res_d.min_value = new_min;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lvl_q   <= lvl_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    carry_q <= carry_d;
    if (accept) begin
      n_q     <= PosW'(cnt_q);
      value_q <= in_data_i.element_value;
      first_q <= PosW'(in_data_i.range_first);
      last_q  <= PosW'(in_data_i.range_last);
      pot_q   <= q_pot_cl;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  strm_ram #(
    .Width (VALUE_W),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/strm_checker.sv @@
// Port-level checker for the sparse table range minimum unit, with its bind.
module strm_checker
  import strm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input strm_pkg::strm_req_t in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input strm_pkg::strm_rsp_t out_data_o
);

  // One item at a time: an accepted item closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input stayed open after an item was accepted");

  // A result only appears as the unit turns idle again
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared while the unit was still busy");

  // Rejected items carry a zero value
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STAT_OK) |-> out_data_o.min_value == '0)
    else $error("error result with nonzero value");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

endmodule

bind sparse_table_range_min_unit strm_checker u_strm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ test/tb_sparse_table_range_min_unit.sv @@
// Self-checking testbench for the sparse table range minimum unit.
module tb_sparse_table_range_min_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import strm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam int RANDOM_ITEMS = 700;

  typedef struct packed {
    strm_req_t item;
    bit        typed;
    strm_rsp_t rsp;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  strm_req_t in_data;
  logic      out_valid;
  logic      out_ready;
  strm_rsp_t out_data;

  // Shadow copy of the table and its fill level
  logic signed [VALUE_W-1:0] level_words [MAX_ELEMENTS][LEVELS];
  int unsigned               loaded_count;

  strm_rsp_t   expected_results [$];
  dir_row_t    directed_rows [$];
  bit          steady;
  int unsigned stall_left;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned ok_seen;
  int unsigned bad_range_seen;
  int unsigned full_seen;

  sparse_table_range_min_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sparse_table_range_min_unit verification failed");
    $finish;
  end

  function automatic logic signed [VALUE_W-1:0] lesser_of(logic signed [VALUE_W-1:0] a,
                                                          logic signed [VALUE_W-1:0] b);
    return (a <= b) ? a : b;
  endfunction

  // Apply one item to the shadow table and return the result it should give.
  function automatic strm_rsp_t table_step(strm_req_t item);
    strm_rsp_t   rsp;
    int unsigned n;
    int unsigned span;
    int unsigned start;
    int unsigned pot;
    int unsigned first;
    int unsigned last;
    rsp   = '0;
    first = item.range_first;
    last  = item.range_last;
    case (item.req_type)
      REQ_CLEAR: begin
        loaded_count = 0;
      end
      REQ_APPEND: begin
        if (loaded_count >= MAX_ELEMENTS) begin
          rsp.status = STAT_FULL;
        end else begin
          n = loaded_count;
          level_words[n][0] = item.element_value;
          // refresh the one window per level that ends at the new element
          for (int j = 1; j < LEVELS; j++) begin
            span = 1 << j;
            if (span > n + 1) break;
            start = n + 1 - span;
            level_words[start][j] = lesser_of(level_words[start][j-1],
                                              level_words[start + span/2][j-1]);
          end
          loaded_count = n + 1;
        end
      end
      REQ_QUERY: begin
        if (first > last || last >= loaded_count) begin
          rsp.status = STAT_BAD_RANGE;
        end else begin
          pot = 0;
          while (((last - first + 1) >> (pot + 1)) != 0) pot++;
          if (pot > LEVELS - 1) pot = LEVELS - 1;
          rsp.min_value = lesser_of(level_words[first][pot],
                                    level_words[last + 1 - (1 << pot)][pot]);
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic strm_req_t make_item(logic [1:0] kind, logic signed [VALUE_W-1:0] value,
                                          int unsigned first, int unsigned last);
    strm_req_t item;
    item.req_type      = kind;
    item.element_value = value;
    item.range_first   = first[IDX_W-1:0];
    item.range_last    = last[IDX_W-1:0];
    return item;
  endfunction

  function automatic dir_row_t mk_row(logic [1:0] kind, logic signed [VALUE_W-1:0] value,
                                      int unsigned first, int unsigned last, bit typed,
                                      logic signed [VALUE_W-1:0] want_value,
                                      logic [1:0] want_status);
    dir_row_t row;
    row.item          = make_item(kind, value, first, last);
    row.typed         = typed;
    row.rsp.min_value = want_value;
    row.rsp.status    = want_status;
    return row;
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return {$urandom, $urandom};
    if (pick < 8) return $signed(64'($urandom_range(0, 200))) - 64'sd100;
    if (pick == 8) return VAL_MAX - $urandom_range(0, 3);
    return VAL_MIN + $urandom_range(0, 3);
  endfunction

  // Query inside the loaded part; caller makes sure the table is not empty.
  function automatic strm_req_t loaded_query();
    int unsigned first;
    int unsigned last;
    first = $urandom_range(0, loaded_count - 1);
    last  = $urandom_range(first, loaded_count - 1);
    return make_item(REQ_QUERY, random_value(), first, last);
  endfunction

  function automatic strm_req_t noise_item();
    return make_item(2'($urandom_range(0, 3)), {$urandom, $urandom},
                     $urandom_range(0, 1023), $urandom_range(0, 1023));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item from a falling edge, hold it until taken, then record its result.
  task automatic send_item(strm_req_t item, bit typed = 1'b0, strm_rsp_t typed_rsp = '0);
    int unsigned gap;
    strm_rsp_t   predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = table_step(item);
    expected_results.push_back(typed ? typed_rsp : predicted);
    if (item.req_type != REQ_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Receiver backpressure
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    strm_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: min_value %0d status %0d",
               out_data.min_value, out_data.status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        case (want.status)
          STAT_OK:        ok_seen++;
          STAT_BAD_RANGE: bad_range_seen++;
          STAT_FULL:      full_seen++;
          default: ;
        endcase
        if (out_data.min_value !== want.min_value) begin
          $error("min_value: expected %0d, got %0d", want.min_value, out_data.min_value);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned appends_left;
    int unsigned queries_left;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    steady         = 1'b0;
    loaded_count   = 0;
    fail_count     = 0;
    items_sent     = 0;
    results_seen   = 0;
    ok_seen        = 0;
    bad_range_seen = 0;
    full_seen      = 0;

    directed_rows = '{
      mk_row(REQ_QUERY,  0,       0,    0,    1'b1, 0,       STAT_BAD_RANGE),
      mk_row(REQ_APPEND, VAL_MAX, 0,    0,    1'b1, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       0,    0,    1'b1, VAL_MAX, STAT_OK),
      mk_row(REQ_APPEND, VAL_MIN, 1023, 1023, 1'b1, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       0,    1,    1'b1, VAL_MIN, STAT_OK),
      mk_row(REQ_QUERY,  0,       1,    0,    1'b1, 0,       STAT_BAD_RANGE),
      mk_row(REQ_QUERY,  0,       0,    2,    1'b1, 0,       STAT_BAD_RANGE),
      mk_row(REQ_UNUSED, -64'sd1, 1023, 1023, 1'b1, 0,       STAT_OK),
      mk_row(REQ_APPEND, -64'sd1, 0,    0,    1'b0, 0,       STAT_OK),
      mk_row(REQ_APPEND, 64'sd0,  0,    0,    1'b0, 0,       STAT_OK),
      mk_row(REQ_APPEND, 64'sd1,  0,    0,    1'b0, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       2,    4,    1'b0, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       0,    4,    1'b0, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       2,    3,    1'b0, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       4,    4,    1'b0, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       1023, 1023, 1'b1, 0,       STAT_BAD_RANGE),
      mk_row(REQ_QUERY,  0,       0,    5,    1'b1, 0,       STAT_BAD_RANGE),
      mk_row(REQ_CLEAR,  -64'sd1, 1023, 1023, 1'b1, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       0,    0,    1'b1, 0,       STAT_BAD_RANGE),
      mk_row(REQ_APPEND, VAL_MIN, 0,    0,    1'b0, 0,       STAT_OK),
      mk_row(REQ_APPEND, VAL_MAX, 0,    0,    1'b0, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       0,    1,    1'b0, 0,       STAT_OK),
      mk_row(REQ_QUERY,  0,       1,    1,    1'b0, 0,       STAT_OK)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].rsp);
    end

    // Mostly clear / fill / query runs with random content, some noise mixed in
    while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
      steady       = ($urandom_range(0, 4) == 0);
      appends_left = ($urandom_range(0, 6) == 0) ? $urandom_range(25, 200)
                                                 : $urandom_range(1, 24);
      queries_left = $urandom_range(1, 16);
      if ($urandom_range(0, 9) != 0 || loaded_count + appends_left > MAX_ELEMENTS) begin
        send_item(make_item(REQ_CLEAR, {$urandom, $urandom},
                            $urandom_range(0, 1023), $urandom_range(0, 1023)));
      end
      while (appends_left > 0 || queries_left > 0) begin
        if (appends_left > 0 && (queries_left == 0 || $urandom_range(0, 1) == 0)) begin
          send_item(make_item(REQ_APPEND, random_value(),
                              $urandom_range(0, 1023), $urandom_range(0, 1023)));
          appends_left--;
        end else begin
          if (loaded_count > 0 && $urandom_range(0, 99) < 85) send_item(loaded_query());
          else send_item(noise_item());
          queries_left--;
        end
      end
    end

    // Fill the whole table, push past capacity, then query across it
    steady = 1'b0;
    send_item(make_item(REQ_CLEAR, 0, 0, 0));
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      send_item(make_item(REQ_APPEND, random_value(), 0, 0));
      if ($urandom_range(0, 7) == 0) send_item(loaded_query());
    end
    repeat (3) send_item(make_item(REQ_APPEND, random_value(), 1023, 1023));
    send_item(make_item(REQ_QUERY, 0, 0, MAX_ELEMENTS - 1));
    send_item(make_item(REQ_QUERY, 0, MAX_ELEMENTS - 1, MAX_ELEMENTS - 1));
    send_item(make_item(REQ_QUERY, 0, MAX_ELEMENTS - 1, MAX_ELEMENTS - 2));
    repeat (40) send_item(loaded_query());
    send_item(make_item(REQ_CLEAR, 0, 0, 0));
    send_item(make_item(REQ_QUERY, 0, 0, 0));
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d results for %0d items, table filled to capacity once.",
             results_seen, items_sent);
    $display("Status mix: %0d ok, %0d bad range, %0d full table.",
             ok_seen, bad_range_seen, full_seen);
    if (fail_count == 0) begin
      $display("sparse_table_range_min_unit verification clean");
    end else begin
      $display("sparse_table_range_min_unit verification failed");
    end
    $finish;
  end

endmodule
